// ----- hdl/dmc_pkg.sv -----
package dmc_pkg;

    // Cache geometry. All sizes are powers of two.
    localparam int NUM_LINES   = 8;
    localparam int BLOCK_BYTES = 4;
    localparam int NUM_BLOCKS  = 32;
    localparam int COUNT_WIDTH = 16;

    localparam int OFF_W      = $clog2(BLOCK_BYTES);
    localparam int LINE_W     = $clog2(NUM_LINES);
    localparam int BLK_W      = $clog2(NUM_BLOCKS);
    localparam int TAG_W      = BLK_W - LINE_W;
    localparam int ADDR_W     = BLK_W + OFF_W;
    localparam int BLOCK_BITS = 8 * BLOCK_BYTES;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;  // latch the request and read both arrays
        logic commit;   // update the cache, memory and counters, load the result
    } dmc_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic out_ready;  // the result register can take a new beat this cycle
    } dmc_status_t;

endpackage

// ----- hdl/direct_mapped_write_through_cache.sv -----
// Direct-mapped, write-through, write-allocate cache in front of a small
// backing memory. Each input beat is one read or write access to a byte
// address (req_type, address, write_data); each output beat reports whether
// the access hit, the byte held at that address before the access, the block
// and line numbers, and four saturating hit and miss counters as they stand
// after the access.
// Both channels use valid and stall: a beat moves on a rising edge where
// valid is high and stall is low. An access goes through capture, which
// latches the request and reads one block of the backing memory and one
// cache line, and commit, which updates line, tag, memory and counters and
// loads the result register that drives the outputs. A new request is
// taken only after the previous access has committed, as the controller
// accepts requests only in its idle state.
// The result register decouples the sides: a new request is taken while a
// finished result is still stalled, and the commit of that request waits
// until the output register is free. Reset clears the controller, the line
// valid bits, the counters and the per-block valid bits that make the
// backing memory read as zero until written; no clearing pass is needed.
module direct_mapped_write_through_cache import dmc_pkg::*; (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic                   req_type,
    input  logic [ADDR_W-1:0]      address,
    input  logic [7:0]             write_data,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic                   hit,
    output logic [7:0]             old_data,
    output logic [BLK_W-1:0]       block_number,
    output logic [LINE_W-1:0]      line_index,
    output logic [COUNT_WIDTH-1:0] read_hits,
    output logic [COUNT_WIDTH-1:0] read_misses,
    output logic [COUNT_WIDTH-1:0] write_hits,
    output logic [COUNT_WIDTH-1:0] write_misses
);

    dmc_cmd_t    cmd;
    dmc_status_t status;

    // The controller sequences each access through capture and commit.
    dmc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    // The datapath holds the arrays, the counters and the result register.
    dmc_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .req_type     (req_type),
        .address      (address),
        .write_data   (write_data),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .hit          (hit),
        .old_data     (old_data),
        .block_number (block_number),
        .line_index   (line_index),
        .read_hits    (read_hits),
        .read_misses  (read_misses),
        .write_hits   (write_hits),
        .write_misses (write_misses)
    );

endmodule

// ----- hdl/dmc_ctrl.sv -----
module dmc_ctrl import dmc_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  dmc_status_t status,
    output dmc_cmd_t    cmd
);

    typedef enum logic [1:0] {
        S_IDLE   = 2'b01,
        S_UPDATE = 2'b10
    } state_t;

    state_t state_reg;
    state_t state_next;

    // A request is taken only in the idle state.
    assign in_stall    = (state_reg != S_IDLE);
    assign cmd.capture = (state_reg == S_IDLE) && in_valid;
    assign cmd.commit  = (state_reg == S_UPDATE) && status.out_ready;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_UPDATE;
                end
            end
            S_UPDATE:
            begin
                if (status.out_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ----- hdl/dmc_dp.sv -----
module dmc_dp import dmc_pkg::*; (
    input  logic                   clk,
    input  logic                   rst_n,
    input  dmc_cmd_t               cmd,
    output dmc_status_t            status,
    input  logic                   req_type,
    input  logic [ADDR_W-1:0]      address,
    input  logic [7:0]             write_data,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic                   hit,
    output logic [7:0]             old_data,
    output logic [BLK_W-1:0]       block_number,
    output logic [LINE_W-1:0]      line_index,
    output logic [COUNT_WIDTH-1:0] read_hits,
    output logic [COUNT_WIDTH-1:0] read_misses,
    output logic [COUNT_WIDTH-1:0] write_hits,
    output logic [COUNT_WIDTH-1:0] write_misses
);

    // Request latched at capture.
    logic              req_write_reg;
    logic [ADDR_W-1:0] req_addr_reg;
    logic [7:0]        req_wdata_reg;

    logic [BLK_W-1:0]  req_blk;
    logic [LINE_W-1:0] req_line;
    logic [TAG_W-1:0]  req_tag;
    logic [OFF_W-1:0]  req_off;
    logic [BLK_W-1:0]  in_blk;
    logic [LINE_W-1:0] in_line;

    // Block-wide arrays and their registered read data.
    logic [BLOCK_BITS-1:0] mem_array  [NUM_BLOCKS];
    logic [BLOCK_BITS-1:0] line_array [NUM_LINES];
    logic [BLOCK_BITS-1:0] mem_rd_reg;
    logic [BLOCK_BITS-1:0] line_rd_reg;
    logic                  mem_ok_reg;
    logic [NUM_BLOCKS-1:0] mem_valid_reg;

    logic [TAG_W-1:0]     line_tag_reg [NUM_LINES];
    logic [NUM_LINES-1:0] line_valid_reg;

    logic [COUNT_WIDTH-1:0] rh_reg, rm_reg, wh_reg, wm_reg;

    logic              out_valid_reg;
    logic              hit_reg;
    logic [7:0]        old_reg;
    logic [BLK_W-1:0]  blk_reg;
    logic [LINE_W-1:0] line_reg;

    logic                  hit_now;
    logic [BLOCK_BITS-1:0] mem_row;
    logic [BLOCK_BITS-1:0] base_row;
    logic [BLOCK_BITS-1:0] line_wr;
    logic [BLOCK_BITS-1:0] mem_wr;
    logic [7:0]            old_now;

    assign req_blk  = req_addr_reg[ADDR_W-1:OFF_W];
    assign req_line = req_blk[LINE_W-1:0];
    assign req_tag  = req_blk[BLK_W-1:LINE_W];
    assign req_off  = req_addr_reg[OFF_W-1:0];
    assign in_blk   = address[ADDR_W-1:OFF_W];
    assign in_line  = in_blk[LINE_W-1:0];

    assign status.out_ready = !out_valid_reg || !out_stall;

    // A memory row never written reads as zero through its per-block valid bit.
    assign mem_row  = mem_ok_reg ? mem_rd_reg : '0;
    assign hit_now  = line_valid_reg[req_line] && (line_tag_reg[req_line] == req_tag);
    assign base_row = hit_now ? line_rd_reg : mem_row;

    always_comb
    begin
        old_now = '0;
        line_wr = base_row;
        mem_wr  = mem_row;
        for (int b = 0; b < BLOCK_BYTES; b++)
        begin
            if (req_off == OFF_W'(b))
            begin
                old_now = base_row[b*8 +: 8];
                if (req_write_reg)
                begin
                    line_wr[b*8 +: 8] = req_wdata_reg;
                    mem_wr[b*8 +: 8]  = req_wdata_reg;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            req_write_reg <= req_type;
            req_addr_reg  <= address;
            req_wdata_reg <= write_data;
            mem_rd_reg    <= mem_array[in_blk];
            mem_ok_reg    <= mem_valid_reg[in_blk];
            line_rd_reg   <= line_array[in_line];
        end
        if (cmd.commit)
        begin
            line_array[req_line]   <= line_wr;
            line_tag_reg[req_line] <= req_tag;
            if (req_write_reg)
            begin
                mem_array[req_blk] <= mem_wr;
            end
            hit_reg  <= hit_now;
            old_reg  <= old_now;
            blk_reg  <= req_blk;
            line_reg <= req_line;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mem_valid_reg  <= '0;
            line_valid_reg <= '0;
            rh_reg         <= '0;
            rm_reg         <= '0;
            wh_reg         <= '0;
            wm_reg         <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.commit)
            begin
                out_valid_reg            <= 1'b1;
                line_valid_reg[req_line] <= 1'b1;
                if (req_write_reg)
                begin
                    mem_valid_reg[req_blk] <= 1'b1;
                    if (hit_now && !(&wh_reg))
                    begin
                        wh_reg <= wh_reg + 1'b1;
                    end
                    if (!hit_now && !(&wm_reg))
                    begin
                        wm_reg <= wm_reg + 1'b1;
                    end
                end
                else
                begin
                    if (hit_now && !(&rh_reg))
                    begin
                        rh_reg <= rh_reg + 1'b1;
                    end
                    if (!hit_now && !(&rm_reg))
                    begin
                        rm_reg <= rm_reg + 1'b1;
                    end
                end
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Counters change only at a commit, which happens only when the result
    // register is empty or its result leaves, so they are driven straight from their registers.
    assign out_valid    = out_valid_reg;
    assign hit          = hit_reg;
    assign old_data     = old_reg;
    assign block_number = blk_reg;
    assign line_index   = line_reg;
    assign read_hits    = rh_reg;
    assign read_misses  = rm_reg;
    assign write_hits   = wh_reg;
    assign write_misses = wm_reg;

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |-> !(out_valid_reg && out_stall))
        else $error("result register overwritten while stalled");

    a_commit_shows: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |=> out_valid_reg)
        else $error("commit did not present a result");

    a_line_filled: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |=> line_valid_reg[req_line])
        else $error("accessed line not valid after commit");

    a_no_double: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.capture && cmd.commit))
        else $error("capture and commit in the same cycle");

endmodule
